>>> rtl/ili_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ili_pkg: shared types and constants for the indexed list block
// Opcodes, status codes, datapath actions and the command/status structs
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ili_pkg;

  // Default number of list entries
  localparam int DepthDef = 16;

  // Fixed field widths
  localparam int OpcodeW = 3;
  localparam int PosW    = 5;
  localparam int WordW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // Operation codes carried by an input item
  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_INSERT = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Action the datapath carries out on a transfer
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_GET,
    ACT_REMOVE,
    ACT_INSERT
  } act_e;

  // Output register state
  typedef enum logic {
    OUT_IDLE,
    OUT_HOLD
  } out_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    exec;
    act_e    act;
    status_e status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_below_fill;
    logic pos_le_fill;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/ili_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ili_ctrl: controller for the indexed list
// Decodes the opcode against the list status into a datapath action and
// status code, and tracks whether the output register holds a result.
// ----------------------------------------------------------------------------
module ili_ctrl
  import ili_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [OpcodeW-1:0] opcode_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  input  wire dp_status_t         dp_status_i,
  output      dp_cmd_t            dp_cmd_o
);

  out_state_e state_q, state_d;
  logic       accept;

  // Output register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OUT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      OUT_IDLE: begin
        if (accept) state_d = OUT_HOLD;
      end
      OUT_HOLD: begin
        if (!accept && out_ready_i) state_d = OUT_IDLE;
      end
      default: state_d = OUT_IDLE;
    endcase
  end

  // Handshake outputs: a new item may enter as the held result leaves
  always_comb begin
    out_valid_o = (state_q == OUT_HOLD);
    in_ready_o  = (state_q == OUT_IDLE) || out_ready_i;
  end

  assign accept = in_valid_i && in_ready_o;

  // Opcode decode against list status
  always_comb begin
    dp_cmd_o.exec   = accept;
    dp_cmd_o.act    = ACT_NONE;
    dp_cmd_o.status = ST_OK;
    unique case (op_e'(opcode_i))
      OP_PUSH: begin
        if (dp_status_i.full) dp_cmd_o.status = ST_FULL;
        else                  dp_cmd_o.act    = ACT_PUSH;
      end
      OP_POP: begin
        if (dp_status_i.empty) dp_cmd_o.status = ST_INDEX;
        else                   dp_cmd_o.act    = ACT_POP;
      end
      OP_GET: begin
        if (!dp_status_i.pos_below_fill) dp_cmd_o.status = ST_INDEX;
        else                             dp_cmd_o.act    = ACT_GET;
      end
      OP_REMOVE: begin
        if (!dp_status_i.pos_below_fill) dp_cmd_o.status = ST_INDEX;
        else                             dp_cmd_o.act    = ACT_REMOVE;
      end
      OP_INSERT: begin
        // fullness wins over a bad index
        if (dp_status_i.full)              dp_cmd_o.status = ST_FULL;
        else if (!dp_status_i.pos_le_fill) dp_cmd_o.status = ST_INDEX;
        else                               dp_cmd_o.act    = ACT_INSERT;
      end
      default: dp_cmd_o.status = ST_INDEX;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ili_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ili_dp: datapath for the indexed list
// One register cell per entry with neighbor shifts, the fill counter, the
// read mux and the result registers.
// ----------------------------------------------------------------------------
module ili_dp
  import ili_pkg::*;
#(
  parameter int DEPTH = DepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [WordW-1:0]   word_in_i,
  input  wire dp_cmd_t            dp_cmd_i,
  output      dp_status_t         dp_status_o,
  output      logic [WordW-1:0]   word_out_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [CountW-1:0]  count_o,
  output      logic               empty_flag_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;

  logic [WordW-1:0] cells_q [DEPTH];
  logic [WordW-1:0] cells_d [DEPTH];
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CmpW-1:0]  fill_x, pos_x;
  logic [IdxW-1:0]  rd_idx;
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] word_out_q;
  logic [StatusW-1:0] status_q;
  logic [CountW-1:0]  count_q;
  logic               empty_q;

  assign fill_x = CmpW'(fill_q);
  assign pos_x  = CmpW'(position_i);

  // Status toward the controller
  always_comb begin
    dp_status_o.full           = (fill_q == CntW'(DEPTH));
    dp_status_o.empty          = (fill_q == '0);
    dp_status_o.pos_below_fill = (pos_x < fill_x);
    dp_status_o.pos_le_fill    = (pos_x <= fill_x);
  end

  // Read address: last entry for pop, the position otherwise
  always_comb begin
    if (dp_cmd_i.act == ACT_POP) rd_idx = IdxW'(fill_x - CmpW'(1));
    else                         rd_idx = IdxW'(pos_x);
  end
  assign rd_word = cells_q[rd_idx];

  // Per-cell next value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] lower_w, upper_w;
    logic [CmpW-1:0]  idx_x;

    assign idx_x = CmpW'(i);

    if (i > 0) begin : g_lower
      assign lower_w = cells_q[i-1];
    end else begin : g_no_lower
      assign lower_w = cells_q[i];
    end

    if (i < DEPTH - 1) begin : g_upper
      assign upper_w = cells_q[i+1];
    end else begin : g_no_upper
      assign upper_w = cells_q[i];
    end

    always_comb begin
      cells_d[i] = cells_q[i];
      if (dp_cmd_i.exec) begin
        case (dp_cmd_i.act)
          ACT_PUSH: begin
            if (idx_x == fill_x) cells_d[i] = word_in_i;
          end
          ACT_INSERT: begin
            // open a gap at the position, shifting the tail up by one
            if (idx_x == pos_x)                          cells_d[i] = word_in_i;
            else if (idx_x > pos_x && idx_x <= fill_x)   cells_d[i] = lower_w;
          end
          ACT_REMOVE: begin
            // close the gap, shifting the tail down by one
            if (idx_x >= pos_x && (idx_x + CmpW'(1)) < fill_x) cells_d[i] = upper_w;
          end
          default: cells_d[i] = cells_q[i];
        endcase
      end
    end
  end

  // Entry cells
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) begin
      cells_q[k] <= cells_d[k];
    end
  end

  // Fill count update
  always_comb begin
    fill_d = fill_q;
    if (dp_cmd_i.exec) begin
      case (dp_cmd_i.act)
        ACT_PUSH, ACT_INSERT: fill_d = fill_q + CntW'(1);
        ACT_POP, ACT_REMOVE:  fill_d = fill_q - CntW'(1);
        default:              fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Result registers, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec) begin
      case (dp_cmd_i.act)
        ACT_POP, ACT_GET, ACT_REMOVE: word_out_q <= rd_word;
        default:                      word_out_q <= '0;
      endcase
      status_q <= dp_cmd_i.status;
      count_q  <= CountW'(fill_d);
      empty_q  <= (fill_d == '0);
    end
  end

  assign word_out_o   = word_out_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign empty_flag_o = empty_q;

endmodule
`default_nettype wire

>>> rtl/indexed_list_insert_delete_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top: bounded ordered list with indexed access
// Push, pop, get, remove and insert on a list of up to DEPTH signed words.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result, in the cycle after it is
// accepted. One item is taken per clock while results drain: each entry sits
// in its own register cell, so the shift that remove and insert need completes
// in the same cycle as the operation. Results sit in an output register; a new
// item is accepted whenever that register is empty or is being drained in the
// same cycle. Failed operations (pop when empty, get/remove at or past the
// end, insert past the end, opcodes 5 to 7) report an index error, and push or
// insert into a full list reports full; neither changes the list. count
// carries the low 5 bits of the entry count after the operation.
module indexed_list_insert_delete_top
  import ili_pkg::*;
#(
  parameter int DEPTH = DepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [OpcodeW-1:0] opcode_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [WordW-1:0]   word_in_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [WordW-1:0]   word_out_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [CountW-1:0]  count_o,
  output      logic               empty_flag_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Controller
  ili_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath
  ili_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .position_i   (position_i),
    .word_in_i    (word_in_i),
    .dp_cmd_i     (dp_cmd),
    .dp_status_o  (dp_status),
    .word_out_o   (word_out_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .empty_flag_o (empty_flag_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted item always shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after input transfer");

  // Failed operations return a zero word
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> word_out_o == '0)
    else $error("nonzero word on failed operation");

  // A full report means the list is at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CountW'(DEPTH))
    else $error("full status with count below capacity");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_flag_o |-> count_o == '0)
    else $error("empty flag with nonzero count");
`endif

endmodule
`default_nettype wire
